/* src/sct_pkg.sv */
// Shared types and constants of the sine, cosine and tangent series unit.
package sct_pkg;

  localparam int MAG_W = 62;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  localparam int VALUE_W = 48;
  localparam logic [VALUE_W-1:0] OUT_POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] OUT_NEG_MAX = {1'b1, {(VALUE_W-1){1'b0}}};

  // Constant divide inside each term: the rounded numerator stays below 2^63 and
  // is divided by multiplying with a 64-bit reciprocal.
  localparam int NUM_W = 63;

  // Tangent divider: 128 restoring steps, two steps a stage.
  localparam int DIV_BITS = 128;
  localparam int DIV_STEPS = 2;

  typedef enum logic [1:0] {
    ACT_SIN = 2'd0,
    ACT_COS = 2'd1,
    ACT_TAN = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIV0 = 2'd1,
    STAT_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } fix_t;

  typedef struct packed {
    action_e          action;
    logic [MAG_W-1:0] x2;
    fix_t             sin_term;
    fix_t             sin_sum;
    fix_t             cos_term;
    fix_t             cos_sum;
  } ser_t;

  typedef struct packed {
    action_e               action;
    fix_t                  s;
    fix_t                  c;
    logic [DIV_BITS-1:0]   num;
    logic [63:0]           rem;
    logic [63:0]           quo;
    logic                  big;
  } div_t;

endpackage

/* src/sct_term.sv */
// One series term for both sine and cosine: multiply, round, constant divide, accumulate.
module sct_term #(
  parameter int TERM_IDX  = 1,
  parameter int FRAC_BITS = 28
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  sct_pkg::ser_t ser_i,
  output logic          vld_o,
  output sct_pkg::ser_t ser_o
);
  import sct_pkg::*;

  localparam int D_ODD  = (2 * TERM_IDX) * (2 * TERM_IDX + 1);
  localparam int D_EVEN = (2 * TERM_IDX - 1) * (2 * TERM_IDX);
  localparam int L_ODD  = $clog2(D_ODD);
  localparam int L_EVEN = $clog2(D_EVEN);
  localparam int NS     = 6;
  localparam int HW     = MAG_W / 2;
  localparam int PW     = 2 * MAG_W;
  localparam int RP_W   = 2 * NUM_W + 1;
  localparam int NH     = 32;

  // Reciprocals ceil(2^(NUM_W+L) / d); the quotient is the product shifted
  // right by NUM_W+L, exact for every numerator below 2^NUM_W.
  localparam logic [RP_W-1:0] M_ODD_W =
    ((RP_W'(1) << (NUM_W + L_ODD)) + RP_W'(D_ODD - 1)) / RP_W'(D_ODD);
  localparam logic [RP_W-1:0] M_EVEN_W =
    ((RP_W'(1) << (NUM_W + L_EVEN)) + RP_W'(D_EVEN - 1)) / RP_W'(D_EVEN);

  // Lane 0 is sine, lane 1 is cosine.
  localparam logic [NUM_W:0] RCP_L [2] = '{M_ODD_W[NUM_W:0], M_EVEN_W[NUM_W:0]};
  localparam int SH_L [2] = '{NUM_W + L_ODD, NUM_W + L_EVEN};
  localparam logic [NUM_W-1:0] HALF_L [2] = '{NUM_W'(D_ODD / 2), NUM_W'(D_EVEN / 2)};

  function automatic fix_t add_sat(input fix_t a, input fix_t b);
    fix_t r;
    logic [MAG_W:0] s;
    s = '0;
    if (a.neg == b.neg) begin
      s = {1'b0, a.mag} + {1'b0, b.mag};
      r.neg = a.neg;
      r.mag = s[MAG_W] ? MAG_MAX : s[MAG_W-1:0];
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg;
      r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg;
      r.mag = b.mag - a.mag;
    end
    if (r.mag == '0) r.neg = 1'b0;
    return r;
  endfunction

  logic [NS-1:0]    vld_q;
  ser_t             ser_q [NS-1];
  logic [PW-1:0]    pp_q [2][4];
  logic [PW-1:0]    prod_q [2];
  logic [NUM_W-1:0] num_q [2];
  logic [RP_W-1:0]  rp_q [2][4];
  logic [RP_W-1:0]  rs_q [2];
  ser_t             out_q;

  logic [MAG_W-1:0] mag_l [2];
  assign mag_l[0] = ser_i.sin_term.mag;
  assign mag_l[1] = ser_i.cos_term.mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [PW:0]      p;
    logic [PW:0]      sh;
    logic [MAG_W-1:0] qv;
    logic [RP_W-1:0]  qs;
    fix_t             st;
    fix_t             ct;
    ser_t             nx;
    if (en_i) begin
      ser_q[0] <= ser_i;
      for (int i = 1; i < NS - 1; i++) ser_q[i] <= ser_q[i-1];
      for (int l = 0; l < 2; l++) begin
        // 31 by 31 partial products of term times x squared.
        pp_q[l][0] <= PW'(mag_l[l][HW-1:0])     * PW'(ser_i.x2[HW-1:0]);
        pp_q[l][1] <= PW'(mag_l[l][HW-1:0])     * PW'(ser_i.x2[MAG_W-1:HW]);
        pp_q[l][2] <= PW'(mag_l[l][MAG_W-1:HW]) * PW'(ser_i.x2[HW-1:0]);
        pp_q[l][3] <= PW'(mag_l[l][MAG_W-1:HW]) * PW'(ser_i.x2[MAG_W-1:HW]);
        prod_q[l] <= pp_q[l][0] + ((pp_q[l][1] + pp_q[l][2]) << HW) + (pp_q[l][3] << MAG_W);
        p  = {1'b0, prod_q[l]} + ((PW+1)'(1) << (FRAC_BITS - 1));
        sh = p >> FRAC_BITS;
        qv = (sh > (PW+1)'(MAG_MAX)) ? MAG_MAX : sh[MAG_W-1:0];
        num_q[l] <= NUM_W'(qv) + HALF_L[l];
        // 32 by 32 partial products of the numerator times the reciprocal.
        rp_q[l][0] <= RP_W'(num_q[l][NH-1:0])      * RP_W'(RCP_L[l][NH-1:0]);
        rp_q[l][1] <= RP_W'(num_q[l][NH-1:0])      * RP_W'(RCP_L[l][NUM_W:NH]);
        rp_q[l][2] <= RP_W'(num_q[l][NUM_W-1:NH])  * RP_W'(RCP_L[l][NH-1:0]);
        rp_q[l][3] <= RP_W'(num_q[l][NUM_W-1:NH])  * RP_W'(RCP_L[l][NUM_W:NH]);
        rs_q[l] <= rp_q[l][0] + ((rp_q[l][1] + rp_q[l][2]) << NH) + (rp_q[l][3] << (2 * NH));
      end
      qs     = rs_q[0] >> SH_L[0];
      st.mag = qs[MAG_W-1:0];
      st.neg = !ser_q[NS-2].sin_term.neg && (st.mag != '0);
      qs     = rs_q[1] >> SH_L[1];
      ct.mag = qs[MAG_W-1:0];
      ct.neg = !ser_q[NS-2].cos_term.neg && (ct.mag != '0);
      nx          = ser_q[NS-2];
      nx.sin_term = st;
      nx.cos_term = ct;
      nx.sin_sum  = add_sat(ser_q[NS-2].sin_sum, st);
      nx.cos_sum  = add_sat(ser_q[NS-2].cos_sum, ct);
      out_q <= nx;
    end
  end

  assign vld_o = vld_q[NS-1];
  assign ser_o = out_q;

endmodule

/* src/sct_div.sv */
// Pipelined restoring divider for tangent, two quotient bits a stage.
module sct_div #(
  parameter int FRAC_BITS = 28
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  sct_pkg::ser_t ser_i,
  output logic          vld_o,
  output sct_pkg::div_t div_o
);
  import sct_pkg::*;

  localparam int NSTG = DIV_BITS / DIV_STEPS;

  function automatic div_t div_step(input div_t x);
    div_t y;
    logic [63:0] den;
    y   = x;
    den = {1'b0, x.c.mag, 1'b0};
    y.rem = {x.rem[62:0], x.num[DIV_BITS-1]};
    y.num = {x.num[DIV_BITS-2:0], 1'b0};
    y.big = x.big || (x.quo[63:62] != 2'b00);
    y.quo = {x.quo[62:0], 1'b0};
    if (y.rem >= den) begin
      y.rem    = y.rem - den;
      y.quo[0] = 1'b1;
    end
    return y;
  endfunction

  function automatic div_t div_stage(input div_t x);
    div_t y;
    y = x;
    for (int j = 0; j < DIV_STEPS; j++) y = div_step(y);
    return y;
  endfunction

  logic [NSTG:0] vld_q;
  div_t          st_q [NSTG+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].action <= ser_i.action;
      st_q[0].s      <= ser_i.sin_sum;
      st_q[0].c      <= ser_i.cos_sum;
      st_q[0].num    <= (DIV_BITS'(ser_i.sin_sum.mag) << (FRAC_BITS + 1))
                        + DIV_BITS'(ser_i.cos_sum.mag);
      st_q[0].rem    <= '0;
      st_q[0].quo    <= '0;
      st_q[0].big    <= 1'b0;
      for (int i = 1; i <= NSTG; i++) st_q[i] <= div_stage(st_q[i-1]);
    end
  end

  assign vld_o = vld_q[NSTG];
  assign div_o = st_q[NSTG];

endmodule

/* src/sine_cosine_tangent_series.sv */
// Top level of the sine, cosine and tangent Taylor series unit.
//
// The slave channel takes one beat per item: tdata holds the angle in radians
// as signed fixed point with FRAC_BITS fraction bits, and tuser holds the action
// (sine, cosine or tangent). The master channel returns one beat per item in
// the same order: tdata holds the 48-bit saturated result, tuser the status.
// The whole datapath is one pipeline with a common advance enable, so while
// no result waits on a stalled receiver a new angle can enter every cycle and
// the sustained rate is one beat per cycle. The pipeline has one input
// register, two stages that form x squared, six stages per series term
// (partial products, product sum, rounding, reciprocal partial products,
// reciprocal sum, accumulate), 65 stages of the tangent divider, which sine
// and cosine beats also pass through, and the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears every valid bit at once, so the block is empty and ready for a
// beat on the first cycle after reset is released.
module sine_cosine_tangent_series #(
  parameter int SERIES_TERMS = 10,
  parameter int FRAC_BITS    = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] angle
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [47:0] value
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import sct_pkg::*;

  // Common advance enable for every stage.
  logic en;
  logic out_vld_q;
  assign en = m_axis_tready || !out_vld_q;
  assign s_axis_tready = en;

  // Input register: action, sign and magnitude of the angle.
  logic        vld0_q, vld1_q, vld2_q;
  action_e     act0_q, act1_q;
  logic        xneg0_q, xneg1_q;
  logic [31:0] xmag0_q, xmag1_q;
  logic [63:0] xsq1_q;
  ser_t        ser2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en) begin
      vld0_q <= s_axis_tvalid;
      vld1_q <= vld0_q;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [64:0] p;
    logic [64:0] sh;
    if (en) begin
      act0_q  <= action_e'(s_axis_tuser);
      xneg0_q <= s_axis_tdata[31];
      xmag0_q <= s_axis_tdata[31] ? (32'd0 - s_axis_tdata) : s_axis_tdata;

      act1_q  <= act0_q;
      xneg1_q <= xneg0_q;
      xmag1_q <= xmag0_q;
      xsq1_q  <= 64'(xmag0_q) * 64'(xmag0_q);

      // Round x squared to nearest and clamp; the series start terms are x and one.
      p  = {1'b0, xsq1_q} + (65'(1) << (FRAC_BITS - 1));
      sh = p >> FRAC_BITS;
      ser2_q.action       <= act1_q;
      ser2_q.x2           <= (sh > 65'(MAG_MAX)) ? MAG_MAX : sh[MAG_W-1:0];
      ser2_q.sin_term.neg <= xneg1_q;
      ser2_q.sin_term.mag <= MAG_W'(xmag1_q);
      ser2_q.sin_sum.neg  <= xneg1_q;
      ser2_q.sin_sum.mag  <= MAG_W'(xmag1_q);
      ser2_q.cos_term.neg <= 1'b0;
      ser2_q.cos_term.mag <= MAG_W'(1) << FRAC_BITS;
      ser2_q.cos_sum.neg  <= 1'b0;
      ser2_q.cos_sum.mag  <= MAG_W'(1) << FRAC_BITS;
    end
  end

  // Chain of series terms; each one adds the next sine and cosine term.
  logic [SERIES_TERMS:0] vld_c;
  ser_t                  ser_c [SERIES_TERMS+1];
  assign vld_c[0] = vld2_q;
  assign ser_c[0] = ser2_q;

  for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
    sct_term #(
      .TERM_IDX  (k),
      .FRAC_BITS (FRAC_BITS)
    ) u_term (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld_c[k-1]),
      .ser_i  (ser_c[k-1]),
      .vld_o  (vld_c[k]),
      .ser_o  (ser_c[k])
    );
  end

  // Tangent quotient; every beat passes so that latency stays uniform.
  logic div_vld;
  div_t div_res;

  sct_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_c[SERIES_TERMS]),
    .ser_i  (ser_c[SERIES_TERMS]),
    .vld_o  (div_vld),
    .div_o  (div_res)
  );

  // Saturate a sign and magnitude value into the 48-bit output format.
  function automatic logic [VALUE_W:0] pack_value(input logic neg, input logic [63:0] mag);
    logic [VALUE_W-1:0] v;
    logic               sat;
    sat = 1'b0;
    if (neg) begin
      if (mag > 64'(OUT_NEG_MAX)) begin
        sat = 1'b1;
        v   = OUT_NEG_MAX;
      end else begin
        v = VALUE_W'(64'd0 - mag);
      end
    end else if (mag > 64'(OUT_POS_MAX)) begin
      sat = 1'b1;
      v   = OUT_POS_MAX;
    end else begin
      v = mag[VALUE_W-1:0];
    end
    return {sat, v};
  endfunction

  logic [VALUE_W-1:0] value_d, value_q;
  status_e            status_d, status_q;
  logic [VALUE_W:0]   pk;
  logic [63:0]        tmag;
  logic               tneg;

  always_comb begin
    tmag     = div_res.big ? 64'(MAG_MAX) : div_res.quo;
    tneg     = (div_res.s.neg != div_res.c.neg) && (tmag != '0);
    value_d  = '0;
    status_d = STAT_OK;
    pk       = '0;
    unique case (div_res.action)
      ACT_SIN: begin
        pk      = pack_value(div_res.s.neg, 64'(div_res.s.mag));
        value_d = pk[VALUE_W-1:0];
      end
      ACT_COS: begin
        pk      = pack_value(div_res.c.neg, 64'(div_res.c.mag));
        value_d = pk[VALUE_W-1:0];
      end
      ACT_TAN: begin
        if (div_res.c.mag == '0) begin
          status_d = STAT_DIV0;
        end else begin
          pk       = pack_value(tneg, tmag);
          value_d  = pk[VALUE_W-1:0];
          status_d = pk[VALUE_W] ? STAT_SAT : STAT_OK;
        end
      end
      default: begin
        value_d  = '0;
        status_d = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = value_q;
  assign m_axis_tuser  = status_q;

endmodule

/* src/sct_checker.sv */
// Port-level checks of the series unit and their binding to the top level.
module sct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import sct_pkg::*;

  // A waiting result holds its beat until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // The pipeline holds as a whole, so input is refused while output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted during output stall");

  // Division by zero always reports a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_DIV0 |-> m_axis_tdata == '0)
    else $error("division by zero with nonzero value");

  // A saturated tangent sits at one of the two range limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_SAT |->
      m_axis_tdata == OUT_POS_MAX || m_axis_tdata == OUT_NEG_MAX)
    else $error("saturated value off the range limits");

endmodule

bind sine_cosine_tangent_series sct_checker u_sct_checker (.*);

/* dv/tb.sv */
// Testbench for the sine, cosine and tangent Taylor series unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sct_pkg::*;

  localparam int TERMS = 10;
  localparam int FRAC = 28;
  localparam int LATENCY = 6 * TERMS + 69;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [63:0] MAGLIM = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [47:0] value;
    logic [1:0]  status;
  } trig_result_t;

  typedef struct {
    bit          neg;
    logic [63:0] mag;
  } sm_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  trig_result_t expected_q[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  sine_cosine_tangent_series #(.SERIES_TERMS(TERMS), .FRAC_BITS(FRAC)) dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // round(a*b / 2^FRAC), clamped to the internal magnitude limit.
  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << (FRAC - 1));
    p = p >> FRAC;
    return (p > 128'(MAGLIM)) ? MAGLIM : p[63:0];
  endfunction

  function automatic sm_t sm_add(sm_t a, sm_t b);
    sm_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg;
      r.mag = a.mag + b.mag;
      if (r.mag > MAGLIM) r.mag = MAGLIM;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg;
      r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg;
      r.mag = b.mag - a.mag;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  function automatic sm_t taylor_sum(sm_t first, logic [63:0] x2, bit odd);
    sm_t term, acc;
    logic [63:0] d, q;
    term = first;
    acc = first;
    for (int n = 1; n <= TERMS; n++) begin
      d = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      q = fx_mul(term.mag, x2);
      term.mag = (q + d / 2) / d;
      term.neg = !term.neg;
      if (term.mag == 0) term.neg = 0;
      acc = sm_add(acc, term);
    end
    return acc;
  endfunction

  function automatic logic [47:0] to_q19(sm_t v, output bit sat);
    sat = 0;
    if (v.neg) begin
      if (v.mag > 64'h8000_0000_0000) begin
        sat = 1;
        return OUT_NEG_MAX;
      end
      return 48'(64'd0 - v.mag);
    end
    if (v.mag > 64'(OUT_POS_MAX)) begin
      sat = 1;
      return OUT_POS_MAX;
    end
    return v.mag[47:0];
  endfunction

  // Tangent magnitude: the divider works on 128 bits and marks quotients
  // that reach 2^63 as clamped.
  function automatic logic [63:0] tan_quot(logic [63:0] s, logic [63:0] c);
    logic [255:0] num;
    logic [255:0] q;
    num = ({192'd0, s} << (FRAC + 1)) + 256'(c);
    q = num / (256'(c) << 1);
    return (q >= (256'd1 << 63)) ? MAGLIM : q[63:0];
  endfunction

  function automatic trig_result_t predict_trig(logic [1:0] act, logic [31:0] raw);
    trig_result_t r;
    sm_t x, one, s, c, t;
    logic [63:0] x2;
    bit sat;
    x.neg = raw[31];
    x.mag = x.neg ? (64'd1 << 32) - 64'(raw) : 64'(raw);
    x2 = fx_mul(x.mag, x.mag);
    one.neg = 0;
    one.mag = 64'd1 << FRAC;
    r.value = '0;
    r.status = STAT_OK;
    case (act)
      ACT_SIN: r.value = to_q19(taylor_sum(x, x2, 1), sat);
      ACT_COS: r.value = to_q19(taylor_sum(one, x2, 0), sat);
      ACT_TAN: begin
        s = taylor_sum(x, x2, 1);
        c = taylor_sum(one, x2, 0);
        if (c.mag == 0) begin
          r.status = STAT_DIV0;
        end else begin
          t.mag = tan_quot(s.mag, c.mag);
          t.neg = (s.neg != c.neg) && t.mag != 0;
          r.value = to_q19(t, sat);
          if (sat) r.status = STAT_SAT;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one beat, holding tvalid until it is taken; tvalid drops only
  // while the sender idles, so beats can follow back to back.
  task automatic send_angle(logic [1:0] act, logic [31:0] ang);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ang;
    s_axis_tuser  <= act;
    expected_q.push_back(predict_trig(act, ang));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_in++;
    @(negedge clk_i);
  endtask

  // The receiver stalls at random on each falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Check each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    trig_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_out++;
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation: value %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tdata !== exp_r.value) begin
          $error("value: expected %h actual %h", exp_r.value, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else if (expected_q.size() != 0 || s_axis_tvalid)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sine_cosine_tangent_series verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(32'd843314856)) - 421657428); // about +-pi/2
      2: return 32'($signed($urandom_range(32'd3373259426)) - 1686629713); // about +-2pi
      default: return 32'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] angles[10];
    angles = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF,
               32'd421657428, -32'd421657428, 32'd843314857, 32'd210828714,
               32'd1264972285};
    foreach (angles[i]) begin
      for (int a = 0; a < 3; a++) send_angle(2'(a), angles[i]);
    end
    // Unused action code.
    send_angle(2'd3, 32'h1234_5678);
    send_angle(2'd3, 32'hFFFF_FFFF);
  endtask

  // Sweep around pi/2 with tangent to reach near-zero cosine and saturation.
  task automatic test_tan_pole();
    for (int i = -40; i <= 40; i++) send_angle(ACT_TAN, 32'(421657428 + i * 7));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_angle(2'($urandom_range(3)), rand_angle());
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_tan_pole();
    idle_pct = 0;  stall_pct = 0;  test_random(360);
    idle_pct = 51; stall_pct = 0;  test_random(360);
    idle_pct = 0;  stall_pct = 51; test_random(360);
    idle_pct = 12; stall_pct = 12; test_random(360);
    s_axis_tvalid <= 1'b0;
    idle_pct = 0;  stall_pct = 0;
    drain();
    $display("Covered %0d beats in, %0d out: sine, cosine, tangent, unused code,",
             beats_in, beats_out);
    $display("edge angles and a tangent pole sweep under four idle and stall mixes.");
    if (errors == 0 && expected_q.size() == 0)
      $display("sine_cosine_tangent_series verification clean");
    else
      $display("sine_cosine_tangent_series verification failed");
    $finish;
  end
endmodule
